// ===== hdl/vfd_scroll_frame_encoder_core_defines.svh =====
`ifndef VFD_SCROLL_FRAME_ENCODER_CORE_DEFINES_SVH
`define VFD_SCROLL_FRAME_ENCODER_CORE_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define VFD_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define VFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/vfd_pkg.sv =====
`timescale 1ns / 1ps

package vfd_pkg;

	localparam int LEN_W      = 7;
	localparam int CHAR_W     = 8;
	localparam int BYTE_W     = 8;
	localparam int S_TDATA_W  = 16;
	localparam int PAT_W      = 16;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	// digit preamble before the bit reversal
	localparam logic [BYTE_W-1:0] LEAD_BYTE = 8'b11000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT0,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	typedef enum logic [1:0] {
		SEL_LEAD,
		SEL_TAIL,
		SEL_HEAD
	} byte_sel_t;

	typedef struct packed {
		logic      load_char;
		logic      frame_start;
		logic      read;
		logic      out_load;
		byte_sel_t out_sel;
		logic      digit_next;
		logic      frame_done;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic digit_zero;
	} sts_t;

	function automatic logic [BYTE_W-1:0] bit_rev(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[BYTE_W-1-i] = v[i];
		end
		return r;
	endfunction

	// head segment byte in the upper half, tail segment byte in the lower half
	function automatic logic [PAT_W-1:0] seg_pattern(input logic [CHAR_W-1:0] ch);
		logic [PAT_W-1:0] p;
		unique case (ch)
			8'h41:   p = 16'h31C6; // A
			8'h42:   p = 16'h2595;
			8'h43:   p = 16'h3003;
			8'h44:   p = 16'h2515;
			8'h45:   p = 16'h30C3;
			8'h46:   p = 16'h30C2;
			8'h47:   p = 16'h3087;
			8'h48:   p = 16'h11C6;
			8'h49:   p = 16'h2411;
			8'h4A:   p = 16'h0107;
			8'h4B:   p = 16'h1262;
			8'h4C:   p = 16'h1003;
			8'h4D:   p = 16'h1B06;
			8'h4E:   p = 16'h1926;
			8'h4F:   p = 16'h3107;
			8'h50:   p = 16'h31C2;
			8'h51:   p = 16'h3127;
			8'h52:   p = 16'h31E2;
			8'h53:   p = 16'h30C5;
			8'h54:   p = 16'h3511;
			8'h55:   p = 16'h1107;
			8'h56:   p = 16'h120A;
			8'h57:   p = 16'h112E;
			8'h58:   p = 16'h0A28;
			8'h59:   p = 16'h0A10;
			8'h5A:   p = 16'h22C9; // Z
			8'h31:   p = 16'h0304; // 1
			8'h32:   p = 16'h21C3;
			8'h33:   p = 16'h21C5;
			8'h34:   p = 16'h11C4;
			8'h35:   p = 16'h30C5;
			8'h36:   p = 16'h30C7;
			8'h37:   p = 16'h2104;
			8'h38:   p = 16'h31C7;
			8'h39:   p = 16'h31C5;
			8'h30:   p = 16'h330F; // 0
			8'h2B:   p = 16'h04D0; // plus
			8'h2D:   p = 16'h00C0; // minus
			8'h2F:   p = 16'h0208; // slash
			8'h2A:   p = 16'h0E38; // star
			8'h27:   p = 16'h0400; // apostrophe
			8'h22:   p = 16'h0400; // double quote
			8'h2E:   p = 16'h0040; // period
			8'h28:   p = 16'h0800; // open paren
			8'h29:   p = 16'h0200; // close paren
			8'h3A:   p = 16'h0208; // colon
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/vfd_ctrl.sv =====
`timescale 1ns / 1ps

module vfd_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         kind,
	output logic         s_tready,
	input  vfd_pkg::sts_t sts,
	output vfd_pkg::cmd_t cmd
);
	import vfd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (kind == KIND_FRAME)) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_EMIT0;
			end
			ST_EMIT0: begin
				if (sts.slot_free) begin
					state_nxt = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				if (sts.slot_free) begin
					state_nxt = ST_EMIT2;
				end
			end
			ST_EMIT2: begin
				if (sts.slot_free) begin
					state_nxt = sts.digit_zero ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		cmd.load_char   = 1'b0;
		cmd.frame_start = 1'b0;
		cmd.read        = 1'b0;
		cmd.out_load    = 1'b0;
		cmd.out_sel     = SEL_LEAD;
		cmd.digit_next  = 1'b0;
		cmd.frame_done  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				cmd.load_char   = s_tvalid && (kind == KIND_LOAD);
				cmd.frame_start = s_tvalid && (kind == KIND_FRAME);
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_EMIT0: begin
				cmd.out_load = sts.slot_free;
				cmd.out_sel  = SEL_LEAD;
			end
			ST_EMIT1: begin
				cmd.out_load = sts.slot_free;
				cmd.out_sel  = SEL_TAIL;
			end
			ST_EMIT2: begin
				cmd.out_load   = sts.slot_free;
				cmd.out_sel    = SEL_HEAD;
				cmd.digit_next = sts.slot_free && !sts.digit_zero;
				cmd.frame_done = sts.slot_free && sts.digit_zero;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/vfd_dp.sv =====
`timescale 1ns / 1ps
`include "vfd_scroll_frame_encoder_core_defines.svh"

module vfd_dp #(
	parameter int DIGITS    = 8,
	parameter int MSG_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [vfd_pkg::CHAR_W-1:0]    char_code,
	input  logic                          message_start,
	input  vfd_pkg::cmd_t                 cmd,
	output vfd_pkg::sts_t                 sts,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [vfd_pkg::BYTE_W-1:0]    m_tdata,
	output logic                          m_tlast
);
	import vfd_pkg::*;

	localparam int AW = $clog2(MSG_DEPTH);
	localparam int DW = $clog2(DIGITS) + 1;
	localparam logic [LEN_W-1:0] MSG_LEN  = LEN_W'(MSG_DEPTH);
	localparam logic [LEN_W:0]   DIGITS_W = (LEN_W + 1)'(DIGITS);
	localparam logic [DW-1:0]    DIG_LAST = DW'(DIGITS - 1);

	logic [CHAR_W-1:0] mem [MSG_DEPTH];

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  pos_q;
	logic [DW-1:0]     digit_q;
	logic [CHAR_W-1:0] rdata_q;
	logic              pad_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;

	logic [LEN_W-1:0] wr_len;
	logic             wr_en;
	logic [LEN_W:0]   pos_end;
	logic             scroll;
	logic [LEN_W:0]   pad_cut;
	logic [LEN_W:0]   digit_ext;
	logic             pad;
	logic [LEN_W:0]   rd_idx;
	logic [PAT_W-1:0] pat;
	logic [BYTE_W-1:0] out_byte;
	logic             out_last;

	// load: a start character restarts the message at entry zero
	assign wr_len = message_start ? '0 : len_q;
	assign wr_en  = cmd.load_char && (wr_len < MSG_LEN);

	assign pos_end   = {1'b0, pos_q} + DIGITS_W;
	assign scroll    = {1'b0, len_q} > DIGITS_W;
	assign pad_cut   = DIGITS_W - {1'b0, len_q};
	assign digit_ext = (LEN_W + 1)'(digit_q);
	assign pad       = !scroll && (digit_ext < pad_cut);
	assign rd_idx    = scroll ? ({1'b0, pos_q} + digit_ext) : (digit_ext - pad_cut);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_len[AW-1:0]] <= char_code;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rdata_q <= mem[rd_idx[AW-1:0]];
			pad_q   <= pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pos_q   <= '0;
			digit_q <= '0;
		end else begin
			if (wr_en) begin
				len_q <= wr_len + 1'b1;
			end else if (cmd.load_char) begin
				len_q <= wr_len;
			end
			if (cmd.frame_start) begin
				// window would run past the end: restart from the first character
				if (pos_end > {1'b0, len_q}) begin
					pos_q <= '0;
				end
				digit_q <= DIG_LAST;
			end else if (cmd.frame_done) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.digit_next) begin
				digit_q <= digit_q - 1'b1;
			end
		end
	end

	assign pat = pad_q ? '0 : seg_pattern(rdata_q);

	always_comb begin
		unique case (cmd.out_sel)
			SEL_LEAD: out_byte = bit_rev(LEAD_BYTE);
			SEL_TAIL: out_byte = bit_rev(pat[BYTE_W-1:0]);
			SEL_HEAD: out_byte = bit_rev(pat[PAT_W-1:BYTE_W]);
			default:  out_byte = '0;
		endcase
	end

	assign out_last = (cmd.out_sel == SEL_HEAD) && (digit_q == '0);

	// output register: the next beat is prepared while the sink holds this one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= out_byte;
			out_last_q <= out_last;
		end
	end

	assign sts.slot_free  = !out_valid_q || m_tready;
	assign sts.digit_zero = (digit_q == '0);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`VFD_ASSERT_HOLDS(a_len_bound, len_q <= MSG_LEN, "message length beyond store depth")
	`VFD_ASSERT_IMPLIES(a_read_in_msg, cmd.read && !pad, rd_idx < {1'b0, len_q}, "window read past message end")
	`VFD_ASSERT_IMPLIES(a_last_ends_frame, cmd.out_load && out_last, cmd.frame_done, "last beat without frame end")

endmodule

// ===== hdl/vfd_scroll_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// scrolling frame encoder for a 16-segment vacuum fluorescent display
// input channel s_*: s_tuser is the kind, 0 loads a character, 1 requests a frame.
//   a load beat appends s_tdata[7:0] to the message store; s_tdata[8] restarts the
//   message first. a load produces no output beats.
// output channel m_*: one spi byte per beat, m_tlast on the final byte of a frame.
// a frame produces 3*DIGITS beats, last digit first: preamble, tail, head segments.
// after a frame beat is accepted, the digit is read from the store, then its preamble is loaded.
// a frame steps through the store read and the preamble, tail and head loads for each digit;
//   no new input beat is taken until the last byte of the frame has been loaded.
// s_tready is low while a frame is being sent, high otherwise; the final byte may
//   still sit in the output register while the next beat is taken.
// a stall on m_tready holds the current beat and freezes the frame sequencer.
// reset clears message length, scroll position and the output valid; store
//   contents are not cleared, only entries within the message are ever used.
module vfd_scroll_frame_encoder_core #(
	parameter int DIGITS    = 8,
	parameter int MSG_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [vfd_pkg::S_TDATA_W-1:0]    s_tdata,  // char_code[7:0], message_start[8], zero fill
	input  logic                             s_tuser,  // kind[0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vfd_pkg::BYTE_W-1:0]       m_tdata,  // spi_byte[7:0]
	output logic                             m_tlast
);
	import vfd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vfd_dp #(
		.DIGITS    (DIGITS),
		.MSG_DEPTH (MSG_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_code     (s_tdata[CHAR_W-1:0]),
		.message_start (s_tdata[CHAR_W]),
		.cmd           (cmd),
		.sts           (sts),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule

// ===== test/vfd_scroll_frame_encoder_core_test.sv =====
`timescale 1ns / 1ps

module vfd_scroll_frame_encoder_core_test;

	import vfd_pkg::*;

	localparam int DIGITS       = 8;
	localparam int MSG_DEPTH    = 64;
	localparam int RANDOM_ITEMS = 320;
	localparam int IDLE_LIMIT   = 2000;
	localparam int END_SETTLE   = 4 * DIGITS + 8;

	typedef struct packed {
		logic [BYTE_W-1:0] spi_byte;
		logic              last_byte;
	} spi_beat_t;

	// mirrors the display state and predicts the spi bytes of every frame
	class vfd_frame_scoreboard;
		logic [CHAR_W-1:0] shadow_chars [MSG_DEPTH];
		int                shadow_len;
		logic [LEN_W-1:0]  shadow_scroll;
		spi_beat_t         expected_bytes[$];
		int                errors;

		function new();
			shadow_len    = 0;
			shadow_scroll = '0;
			errors        = 0;
		endfunction

		static function logic [BYTE_W-1:0] mirror_byte(logic [BYTE_W-1:0] v);
			return {<<{v}};
		endfunction

		// head byte in [15:8], tail byte in [7:0]
		static function logic [15:0] glyph_segments(logic [CHAR_W-1:0] ch);
			case (ch)
				"A": return 16'h31C6;  "B": return 16'h2595;  "C": return 16'h3003;
				"D": return 16'h2515;  "E": return 16'h30C3;  "F": return 16'h30C2;
				"G": return 16'h3087;  "H": return 16'h11C6;  "I": return 16'h2411;
				"J": return 16'h0107;  "K": return 16'h1262;  "L": return 16'h1003;
				"M": return 16'h1B06;  "N": return 16'h1926;  "O": return 16'h3107;
				"P": return 16'h31C2;  "Q": return 16'h3127;  "R": return 16'h31E2;
				"S": return 16'h30C5;  "T": return 16'h3511;  "U": return 16'h1107;
				"V": return 16'h120A;  "W": return 16'h112E;  "X": return 16'h0A28;
				"Y": return 16'h0A10;  "Z": return 16'h22C9;
				"0": return 16'h330F;  "1": return 16'h0304;  "2": return 16'h21C3;
				"3": return 16'h21C5;  "4": return 16'h11C4;  "5": return 16'h30C5;
				"6": return 16'h30C7;  "7": return 16'h2104;  "8": return 16'h31C7;
				"9": return 16'h31C5;
				"+": return 16'h04D0;  "-": return 16'h00C0;  "/": return 16'h0208;
				"*": return 16'h0E38;  "'": return 16'h0400;  "\"": return 16'h0400;
				".": return 16'h0040;  "(": return 16'h0800;  ")": return 16'h0200;
				":": return 16'h0208;
				default: return 16'h0000;
			endcase
		endfunction

		function void note_item(logic kind, logic [CHAR_W-1:0] ch, logic start);
			logic [CHAR_W-1:0] window [DIGITS];
			logic [15:0]       seg;
			spi_beat_t         beat;
			int                idx;
			int                pad;
			if (kind == KIND_LOAD) begin
				if (start)
					shadow_len = 0;
				// store full: character is dropped
				if (shadow_len < MSG_DEPTH) begin
					shadow_chars[shadow_len] = ch;
					shadow_len++;
				end
				return;
			end
			if (int'(shadow_scroll) + DIGITS > shadow_len)
				shadow_scroll = '0;
			pad = DIGITS - shadow_len;
			for (int d = 0; d < DIGITS; d++) begin
				if (shadow_len > DIGITS) begin
					idx = int'(shadow_scroll) + d;
					window[d] = (idx < MSG_DEPTH) ? shadow_chars[idx] : CHAR_W'(" ");
				end else if (d < pad) begin
					window[d] = " ";
				end else begin
					window[d] = shadow_chars[d - pad];
				end
			end
			// rightmost digit goes out first
			for (int d = DIGITS - 1; d >= 0; d--) begin
				seg = glyph_segments(window[d]);
				beat.spi_byte  = mirror_byte(LEAD_BYTE);
				beat.last_byte = 1'b0;
				expected_bytes.push_back(beat);
				beat.spi_byte  = mirror_byte(seg[7:0]);
				expected_bytes.push_back(beat);
				beat.spi_byte  = mirror_byte(seg[15:8]);
				beat.last_byte = (d == 0);
				expected_bytes.push_back(beat);
			end
			shadow_scroll = shadow_scroll + 1'b1;
		endfunction

		function void check_spi_byte(logic [BYTE_W-1:0] got_byte, logic got_last);
			spi_beat_t want;
			if (expected_bytes.size() == 0) begin
				$error("spi_byte: expected none, got %02h", got_byte);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (got_byte !== want.spi_byte) begin
				$error("spi_byte: expected %02h, got %02h", want.spi_byte, got_byte);
				errors++;
			end
			if (got_last !== want.last_byte) begin
				$error("last_byte: expected %0b, got %0b", want.last_byte, got_last);
				errors++;
			end
		endfunction

		function int pending_count();
			return expected_bytes.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = KIND_LOAD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;
	logic                 m_tlast;

	vfd_frame_scoreboard frames;
	int                  idle_cycles = 0;
	int unsigned         rx_cycle    = 0;
	int                  burst_left  = 0;
	int                  items_sent  = 0;
	bit                  valid_up    = 1'b0;

	vfd_scroll_frame_encoder_core #(
		.DIGITS   (DIGITS),
		.MSG_DEPTH(MSG_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver stall pattern cycles through free, random, sparse and mostly-ready phases
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[10:9])
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
			2'd2:    m_tready <= (rx_cycle[1:0] == 2'd0);
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				frames.check_spi_byte(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				frames.note_item(s_tuser, s_tdata[CHAR_W-1:0], s_tdata[CHAR_W]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic drop_valid();
		if (valid_up) begin
			s_tvalid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	// bursts of back-to-back beats separated by random gaps
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		drop_valid();
		repeat ($urandom_range(1, 6)) @(posedge clk);
		burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
	endtask

	task automatic send_item(logic kind, logic [CHAR_W-1:0] ch, logic start);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - CHAR_W - 1){1'b0}}, start, ch};
		valid_up = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		pace_sender();
	endtask

	task automatic load_char(logic [CHAR_W-1:0] ch, logic start);
		send_item(KIND_LOAD, ch, start);
	endtask

	// frame beats carry random filler in the unused fields
	task automatic request_frame();
		send_item(KIND_FRAME, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic hold_until_drained();
		drop_valid();
		@(posedge clk);
		while (frames.pending_count() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		string glyphs;
		glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-/*'\".(): ";
		if ($urandom_range(0, 3) == 0)
			return CHAR_W'($urandom_range(0, 255));
		return glyphs.getc($urandom_range(0, glyphs.len() - 1));
	endfunction

	task automatic run_directed();
		string word;
		// empty message right after reset, all blanks
		send_item(KIND_FRAME, 8'hFF, 1'b1);
		load_char(8'h00, 1'b1);
		request_frame();
		load_char(8'hFF, 1'b0);
		load_char("a", 1'b0);
		request_frame();
		// message of exactly one window, no scrolling
		word = "09AZ+-/*";
		for (int i = 0; i < word.len(); i++)
			load_char(word.getc(i), i == 0);
		request_frame();
		request_frame();
		// one past a window: scroll then wrap back to the start
		load_char("(", 1'b0);
		request_frame();
		request_frame();
		request_frame();
		// restart keeps the scroll position
		load_char(":", 1'b1);
		request_frame();
	endtask

	task automatic run_random();
		int  msg_len;
		int  frame_count;
		int  roll;
		bit  first_seq;
		first_seq = 1'b1;
		while (items_sent < RANDOM_ITEMS) begin
			if (!first_seq && $urandom_range(0, 9) == 0) begin
				// noise: any mix of kinds and flags
				repeat ($urandom_range(1, 8))
					send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end else begin
				roll = $urandom_range(0, 19);
				if (first_seq)
					msg_len = MSG_DEPTH + 4;
				else if (roll < 14)
					msg_len = $urandom_range(1, 2 * DIGITS);
				else if (roll < 18)
					msg_len = $urandom_range(2 * DIGITS + 1, MSG_DEPTH - 1);
				else
					msg_len = $urandom_range(MSG_DEPTH, MSG_DEPTH + 6);
				// most messages start fresh, some append to the current one
				roll = $urandom_range(0, 4);
				for (int i = 0; i < msg_len; i++) begin
					load_char(pick_char(), (i == 0) && (roll != 0));
					if ($urandom_range(0, 19) == 0)
						request_frame();
				end
				frame_count = $urandom_range(1, 6);
				if (msg_len > DIGITS && $urandom_range(0, 5) == 0)
					frame_count = $urandom_range(DIGITS, 2 * DIGITS);
				repeat (frame_count)
					request_frame();
			end
			first_seq = 1'b0;
			if ($urandom_range(0, 7) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		frames = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		hold_until_drained();
		run_random();
		drop_valid();
		while (frames.pending_count() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (frames.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
